/* hdl/ccsc_pkg.sv */
// ----------------------------------------------------------------------------
// ccsc_pkg
// Shared types and constants of the character-cell sprite compositor.
// ----------------------------------------------------------------------------
package ccsc_pkg;

  // default frame store geometry
  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  // depth of the command queue between front and back
  localparam int QDEPTH = 4;

  // glyph codes
  localparam logic [7:0] GLYPH_SPACE = 8'h20;
  localparam logic [7:0] GLYPH_AT    = 8'h40;

  // request kinds on s_tuser
  localparam logic REQ_BLIT    = 1'b0;
  localparam logic REQ_REFRESH = 1'b1;

  // result kinds on m_tuser
  localparam logic [1:0] RK_CELL  = 2'd0;
  localparam logic [1:0] RK_NOCHG = 2'd1;
  localparam logic [1:0] RK_VIS   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_CAMERA = 2'd0;
  localparam logic [1:0] CFG_ROWS   = 2'd1;
  localparam logic [1:0] CFG_COLS   = 2'd2;

  // configuration registers
  typedef struct packed {
    logic [11:0] camera_column;
    logic [6:0]  screen_rows;
    logic [6:0]  screen_cols;
  } cfg_t;

  // decoded command handed from front to back
  typedef struct packed {
    logic       is_refresh;
    logic       draw;       // blit: texel lands on screen and is opaque
    logic       last;       // blit: last texel of the sprite
    logic       in_range;   // refresh: row is in use
    logic [6:0] row;        // blit screen row, or refresh row
    logic [5:0] col;        // blit screen column
    logic [7:0] glyph;      // glyph to store ('@' already mapped)
  } cmd_t;

  // one result word
  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] row;
    logic [5:0] col;
    logic [7:0] glyph;
    logic       vis;
    logic       last;
  } res_t;

endpackage

/* hdl/ccsc_front.sv */
// ----------------------------------------------------------------------------
// ccsc_front
// Input side: clips a texel against the screen and camera window, maps
// glyphs and range-checks refresh rows, then pushes a command word.
// ----------------------------------------------------------------------------
module ccsc_front #(
  parameter int MAX_ROWS = ccsc_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = ccsc_pkg::MAX_COLS_DEF
) (
  input  logic              clearing,
  input  ccsc_pkg::cfg_t    cfg,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [47:0]       s_tdata,
  input  logic              s_tuser,
  input  logic              s_tlast,
  input  logic              q_full,
  output logic              q_push,
  output ccsc_pkg::cmd_t    q_cmd
);
  import ccsc_pkg::*;

  logic [6:0]  sprite_top;
  logic [12:0] sprite_left;
  logic [5:0]  texel_row;
  logic [5:0]  texel_col;
  logic [7:0]  texel_glyph;
  logic [5:0]  refresh_row;
  logic [7:0]  row_sum;
  logic [14:0] col_sum;
  logic        row_ok;
  logic        col_ok;
  logic        rrow_ok;

  // unpack the input word
  assign sprite_top  = s_tdata[6:0];
  assign sprite_left = s_tdata[19:7];
  assign texel_row   = s_tdata[25:20];
  assign texel_col   = s_tdata[31:26];
  assign texel_glyph = s_tdata[39:32];
  assign refresh_row = s_tdata[45:40];

  // screen position of the texel
  assign row_sum = {sprite_top[6], sprite_top} + {2'b00, texel_row};
  assign col_sum = {{2{sprite_left[12]}}, sprite_left} + {9'b0, texel_col}
                   - {3'b0, cfg.camera_column};

  // clip against rows and columns in use
  assign row_ok = !row_sum[7] && (row_sum[6:0] < cfg.screen_rows)
                  && (32'(row_sum[6:0]) < MAX_ROWS);
  assign col_ok = !col_sum[14] && (col_sum[13:0] < 14'(cfg.screen_cols))
                  && (32'(col_sum[13:0]) < MAX_COLS);
  assign rrow_ok = (7'(refresh_row) < cfg.screen_rows)
                   && (32'(refresh_row) < MAX_ROWS);

  // handshake: hold off while the queue is full and during the post-reset clear
  assign s_tready = !q_full && !clearing;
  assign q_push   = s_tvalid && s_tready;

  // build the command word
  always_comb begin
    q_cmd            = '0;
    q_cmd.is_refresh = (s_tuser == REQ_REFRESH);
    q_cmd.last       = s_tlast;
    q_cmd.in_range   = rrow_ok;
    q_cmd.col        = col_sum[5:0];
    q_cmd.glyph      = (texel_glyph == GLYPH_AT) ? GLYPH_SPACE : texel_glyph;
    q_cmd.draw       = (texel_glyph != GLYPH_SPACE) && row_ok && col_ok;
    if (s_tuser == REQ_REFRESH) begin
      q_cmd.row = {1'b0, refresh_row};
    end else begin
      q_cmd.row = row_sum[6:0];
    end
  end

endmodule

/* hdl/ccsc_fifo.sv */
// ----------------------------------------------------------------------------
// ccsc_fifo
// Short command queue decoupling the front from the back.
// ----------------------------------------------------------------------------
module ccsc_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ccsc_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output ccsc_pkg::cmd_t  head
);
  import ccsc_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  cmd_t             mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full  = (count == (PTR_W+1)'(QDEPTH));
  assign valid = (count != '0);
  assign head  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/ccsc_back.sv */
// ----------------------------------------------------------------------------
// ccsc_back
// Execution side: owns both frame stores, draws texels, scans and blanks
// refreshed rows, and drives the output register.
// ----------------------------------------------------------------------------
module ccsc_back #(
  parameter int MAX_ROWS = ccsc_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = ccsc_pkg::MAX_COLS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  ccsc_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  ccsc_pkg::cmd_t  q_cmd,
  output logic            q_pop,
  output logic            clearing,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [23:0]     m_tdata,
  output logic [1:0]      m_tuser,
  output logic            m_tlast
);
  import ccsc_pkg::*;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = MAX_ROWS << COL_W;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t            state;
  logic [7:0]        cur_mem  [DEPTH];
  logic [7:0]        prev_mem [DEPTH];
  logic [ADDR_W-1:0] clr_addr;
  logic              visible_seen;

  // scan state
  logic [ROW_W-1:0]  scan_row;
  logic [5:0]        scan_rrow;
  logic [COL_W:0]    rd_col;
  logic              st_vld;
  logic [COL_W-1:0]  st_col;
  logic [7:0]        cur_q;
  logic [7:0]        prev_q;
  logic              pend_vld;
  logic [COL_W-1:0]  pend_col;
  logic [7:0]        pend_glyph;

  // output register
  res_t              out_res;

  // control
  logic              out_free;
  logic              emit;
  res_t              emit_res;
  logic              cur_we;
  logic [ADDR_W-1:0] cur_waddr;
  logic [7:0]        cur_wdata;
  logic              prev_we;
  logic [ADDR_W-1:0] prev_waddr;
  logic              rd_en;
  logic              rd_done;
  logic              need_emit;
  logic              can_go;
  logic              advance;

  assign clearing = (state == S_CLEAR);
  assign out_free = !m_tvalid || m_tready;
  assign rd_done  = (rd_col == (COL_W+1)'(MAX_COLS));

  // changed cell in the compare stage
  assign need_emit = st_vld && (7'(st_col) < cfg.screen_cols) && (cur_q != prev_q);
  assign can_go    = !(need_emit && pend_vld) || out_free;
  assign advance   = !st_vld || can_go;

  // per-state control
  always_comb begin
    q_pop     = 1'b0;
    emit      = 1'b0;
    emit_res  = '0;
    cur_we    = 1'b0;
    cur_waddr = clr_addr;
    cur_wdata = GLYPH_SPACE;
    prev_we   = 1'b0;
    prev_waddr = clr_addr;
    rd_en     = 1'b0;
    case (state)
      S_CLEAR: begin
        cur_we  = 1'b1;
        prev_we = 1'b1;
      end
      S_IDLE: begin
        if (q_valid) begin
          if (!q_cmd.is_refresh) begin
            if (!q_cmd.last || out_free) begin
              q_pop     = 1'b1;
              cur_we    = q_cmd.draw;
              cur_waddr = {ROW_W'(q_cmd.row), COL_W'(q_cmd.col)};
              cur_wdata = q_cmd.glyph;
              if (q_cmd.last) begin
                emit          = 1'b1;
                emit_res.kind = RK_VIS;
                emit_res.vis  = visible_seen || q_cmd.draw;
                emit_res.last = 1'b1;
              end
            end
          end else if (!q_cmd.in_range) begin
            if (out_free) begin
              q_pop         = 1'b1;
              emit          = 1'b1;
              emit_res.kind = RK_NOCHG;
              emit_res.row  = q_cmd.row[5:0];
              emit_res.last = 1'b1;
            end
          end else begin
            q_pop = 1'b1;
          end
        end
      end
      S_SCAN: begin
        rd_en = advance && !rd_done;
        if (st_vld && can_go) begin
          cur_we     = 1'b1;
          cur_waddr  = {scan_row, st_col};
          cur_wdata  = GLYPH_SPACE;
          prev_we    = need_emit;
          prev_waddr = {scan_row, st_col};
          if (need_emit && pend_vld) begin
            emit           = 1'b1;
            emit_res.kind  = RK_CELL;
            emit_res.row   = scan_rrow;
            emit_res.col   = 6'(pend_col);
            emit_res.glyph = pend_glyph;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          emit          = 1'b1;
          emit_res.row  = scan_rrow;
          emit_res.last = 1'b1;
          if (pend_vld) begin
            emit_res.kind  = RK_CELL;
            emit_res.col   = 6'(pend_col);
            emit_res.glyph = pend_glyph;
          end else begin
            emit_res.kind = RK_NOCHG;
          end
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // frame stores: one write port each, registered read ports sharing one address
  always_ff @(posedge clk) begin
    if (cur_we) begin
      cur_mem[cur_waddr] <= cur_wdata;
    end
    if (prev_we) begin
      prev_mem[prev_waddr] <= clearing ? GLYPH_SPACE : cur_q;
    end
    if (rd_en) begin
      cur_q  <= cur_mem[{scan_row, rd_col[COL_W-1:0]}];
      prev_q <= prev_mem[{scan_row, rd_col[COL_W-1:0]}];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      visible_seen <= 1'b0;
      rd_col       <= '0;
      st_vld       <= 1'b0;
      pend_vld     <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            if (!q_cmd.is_refresh) begin
              visible_seen <= q_cmd.last ? 1'b0 : (visible_seen || q_cmd.draw);
            end else if (q_cmd.in_range) begin
              state     <= S_SCAN;
              scan_row  <= ROW_W'(q_cmd.row);
              scan_rrow <= q_cmd.row[5:0];
              rd_col    <= '0;
              st_vld    <= 1'b0;
              pend_vld  <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          if (advance) begin
            st_vld <= rd_en;
            st_col <= rd_col[COL_W-1:0];
            if (rd_en) begin
              rd_col <= rd_col + 1'b1;
            end
          end
          if (st_vld && can_go && need_emit) begin
            pend_vld   <= 1'b1;
            pend_col   <= st_col;
            pend_glyph <= cur_q;
          end
          if (rd_done && !st_vld) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_res <= emit_res;
    end
  end

  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;
  assign m_tdata = {3'b000, out_res.vis, out_res.glyph, out_res.col, out_res.row};

endmodule

/* hdl/char_cell_sprite_compositor_core.sv */
// ----------------------------------------------------------------------------
// char_cell_sprite_compositor_core
// Character-cell compositor: sprite texel blits into a current frame,
// row refreshes that emit changed cells against a previous frame.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream takes one request word: a texel blit (s_tuser 0, s_tlast on
//   the sprite's last texel) or a row refresh (s_tuser 1).
//   m_* stream returns result words; m_tlast marks the final word of a
//   request. Blits without s_tlast return nothing.
//   cfg_* writes camera column, rows in use and columns in use; write only
//   while no request is in flight.
//   A visibility report or an out-of-range no-change word passes through
//   the command queue and is then registered in the output register.
//   A blit is handled without leaving the back end's idle state; a refresh of an in-use
//   row runs a one-cell-per-cycle compare and blank sweep over the frame
//   store read ports while the output does not stall. A four-entry
//   command queue lets requests be accepted while the back end is busy.
//   Reset: both frame stores are cleared to space, one cell per cycle,
//   over all MAX_ROWS * 2**clog2(MAX_COLS) cells (4096 by default); s_tready
//   stays low during that pass.
//   A stall on m_tready holds the result register and pauses the sweep;
//   the queue keeps taking requests until full.
// ----------------------------------------------------------------------------
module char_cell_sprite_compositor_core #(
  parameter int MAX_ROWS = ccsc_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = ccsc_pkg::MAX_COLS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [11:0] cfg_wdata,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // sprite_top, sprite_left, texel_row, texel_col,
                                // texel_glyph, refresh_row, zero pad
  input  logic        s_tuser,  // req_type
  input  logic        s_tlast,  // last_texel
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // cell_row, cell_col, cell_glyph, sprite_visible,
                                // zero pad
  output logic [1:0]  m_tuser,  // result_kind
  output logic        m_tlast   // last_of_run
);
  import ccsc_pkg::*;

  cfg_t cfg;
  logic clearing;
  logic q_push;
  cmd_t q_in;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_head;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.camera_column <= '0;
      cfg.screen_rows   <= 7'd64;
      cfg.screen_cols   <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        CFG_CAMERA: cfg.camera_column <= cfg_wdata;
        CFG_ROWS:   cfg.screen_rows   <= cfg_wdata[6:0];
        CFG_COLS:   cfg.screen_cols   <= cfg_wdata[6:0];
        default:    cfg.camera_column <= cfg.camera_column;
      endcase
    end
  end

  ccsc_front #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_front (
    .clearing(clearing),
    .cfg     (cfg),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_in)
  );

  ccsc_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_cmd(q_in),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head    (q_head)
  );

  ccsc_back #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_cmd   (q_head),
    .q_pop   (q_pop),
    .clearing(clearing),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  // no results and no requests taken during the clear pass
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!m_tvalid && !s_tready))
    else $error("activity during frame store clear");

  // visibility report always closes its run
  a_vis_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == RK_VIS)) |-> m_tlast)
    else $error("visibility report without last");

  // no-change result closes its run and carries no visibility
  a_nochg: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == RK_NOCHG)) |-> (m_tlast && !m_tdata[20]))
    else $error("malformed no-change result");

  // queue never pops while empty
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue pop while empty");

endmodule
